FILE: sv/ffa_pkg.sv
package ffa_pkg;

   // Heap geometry
   localparam int HEAP_UNITS = 4096;
   localparam int ADDR_W     = 12;
   localparam int SIZE_W     = 13;
   localparam int UNIT_SHIFT = 4;   // 16-byte units
   localparam int UNIT_BYTES = 1 << UNIT_SHIFT;

   localparam logic [SIZE_W-1:0] GROW_MIN_RESET = 13'd1024;
   localparam logic [SIZE_W-1:0] STEP_LIMIT     = 13'd4096;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic STAT_OK  = 1'b0;
   localparam logic STAT_OOM = 1'b1;

   // One free-list header: link and size in units
   typedef struct packed {
      logic [ADDR_W-1:0] next;
      logic [SIZE_W-1:0] size;
   } hdr_type;

   localparam int HDR_W = $bits(hdr_type);

   // Header memory access from the controller
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      hdr_type           wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   // Finished result handed to the output stage
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic              status;
   } res_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_A_PREV,
      ST_A_FETCH,
      ST_A_WALK,
      ST_A_SPLIT,
      ST_G_WR,
      ST_I_BL,
      ST_I_ROV,
      ST_I_WALK,
      ST_I_N,
      ST_I_W2,
      ST_DONE
   } state_type;

endpackage

FILE: sv/ffa_ram.sv
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port (old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/ffa_ctrl.sv
module ffa_ctrl
   import ffa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [15:0]       req_request_bytes,
   input  logic [ADDR_W-1:0] req_block_address,
   input  logic [SIZE_W-1:0] grow_min,
   input  hdr_type           mem_rdata,
   output mem_req_type       mem_req,
   input  logic              rsp_free,
   output res_type           res
);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] rover_ff, rover_in;
   logic [SIZE_W-1:0] brk_ff, brk_in;
   logic [ADDR_W-1:0] prev_ff, prev_in;
   logic [ADDR_W-1:0] p_ff, p_in;
   hdr_type           pv_ff, pv_in;
   hdr_type           cur_ff, cur_in;
   logic [ADDR_W-1:0] bp_ff, bp_in;
   hdr_type           bh_ff, bh_in;
   logic [SIZE_W-1:0] units_ff, units_in;
   logic [SIZE_W-1:0] amt_ff, amt_in;
   logic [ADDR_W-1:0] q_ff, q_in;
   logic [SIZE_W-1:0] steps_ff, steps_in;
   logic              grow_ff, grow_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic              res_stat_ff, res_stat_in;

   // Scratch values
   logic [16:0]       byte_sum;
   logic [SIZE_W-1:0] req_units;
   logic [SIZE_W-1:0] rem;
   logic [ADDR_W-1:0] q_addr;
   logic [SIZE_W-1:0] amount;
   logic [SIZE_W:0]   brk_sum;
   logic [ADDR_W-1:0] nx;
   logic              ins_found;
   logic [SIZE_W:0]   b_end;
   logic [SIZE_W:0]   p_end;
   hdr_type           b_new;
   hdr_type           p_eff;
   hdr_type           p_new;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         rover_ff <= '0;
         brk_ff   <= 13'd1;
         grow_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rover_ff <= rover_in;
         brk_ff   <= brk_in;
         grow_ff  <= grow_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      prev_ff     <= prev_in;
      p_ff        <= p_in;
      pv_ff       <= pv_in;
      cur_ff      <= cur_in;
      bp_ff       <= bp_in;
      bh_ff       <= bh_in;
      units_ff    <= units_in;
      amt_ff      <= amt_in;
      q_ff        <= q_in;
      steps_ff    <= steps_in;
      res_addr_ff <= res_addr_in;
      res_stat_ff <= res_stat_in;
   end

   // Arithmetic shared by the states
   always_comb begin
      byte_sum  = {1'b0, req_request_bytes} + 17'(UNIT_BYTES - 1);
      req_units = SIZE_W'(byte_sum >> UNIT_SHIFT) + 13'd1;
      rem       = mem_rdata.size - units_ff;
      q_addr    = p_ff + rem[ADDR_W-1:0];
      amount    = (units_ff < grow_min) ? grow_min : units_ff;
      brk_sum   = {1'b0, brk_ff} + {1'b0, amount};
      nx        = mem_rdata.next;
      ins_found = ((bp_ff > p_ff) && (bp_ff < nx)) ||
                  ((p_ff >= nx) && ((bp_ff > p_ff) || (bp_ff < nx))) ||
                  (steps_ff >= STEP_LIMIT);
      // merge with the upper neighbor
      b_end = {2'b0, bp_ff} + {1'b0, bh_ff.size};
      if (b_end == {2'b0, cur_ff.next}) begin
         b_new.size = bh_ff.size + mem_rdata.size;
         b_new.next = mem_rdata.next;
      end else begin
         b_new.size = bh_ff.size;
         b_new.next = cur_ff.next;
      end
      // merge with the lower neighbor, seen after the first write
      p_eff = (p_ff == bp_ff) ? bh_ff : cur_ff;
      p_end = {2'b0, p_ff} + {1'b0, p_eff.size};
      if (p_end == {2'b0, bp_ff}) begin
         p_new.size = p_eff.size + bh_ff.size;
         p_new.next = bh_ff.next;
      end else begin
         p_new.size = p_eff.size;
         p_new.next = bp_ff;
      end
   end

   // Next state and outputs
   always_comb begin
      state_in    = state_ff;
      rover_in    = rover_ff;
      brk_in      = brk_ff;
      prev_in     = prev_ff;
      p_in        = p_ff;
      pv_in       = pv_ff;
      cur_in      = cur_ff;
      bp_in       = bp_ff;
      bh_in       = bh_ff;
      units_in    = units_ff;
      amt_in      = amt_ff;
      q_in        = q_ff;
      steps_in    = steps_ff;
      grow_in     = grow_ff;
      res_addr_in = res_addr_ff;
      res_stat_in = res_stat_ff;

      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = '0;
      mem_req.wr_data = '0;
      mem_req.rd_addr = rover_ff;

      res.valid  = 1'b0;
      res.addr   = res_addr_ff;
      res.status = res_stat_ff;

      req_stall = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_INIT: begin
            // sentinel: size zero, linked to itself
            mem_req.wr_en = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               steps_in = '0;
               if (req_func == FUNC_ALLOC) begin
                  units_in        = req_units;
                  mem_req.rd_addr = rover_ff;
                  state_in        = ST_A_PREV;
               end else begin
                  bp_in           = req_block_address - 12'd1;
                  mem_req.rd_addr = req_block_address - 12'd1;
                  grow_in         = 1'b0;
                  state_in        = ST_I_BL;
               end
            end
         end
         ST_A_PREV: begin
            prev_in         = rover_ff;
            pv_in           = mem_rdata;
            p_in            = mem_rdata.next;
            mem_req.rd_addr = mem_rdata.next;
            state_in        = ST_A_WALK;
         end
         ST_A_FETCH: begin
            mem_req.rd_addr = p_ff;
            state_in        = ST_A_WALK;
         end
         ST_A_WALK: begin
            priority if (mem_rdata.size == units_ff) begin
               // exact fit: unlink
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = prev_ff;
               mem_req.wr_data = '{next: mem_rdata.next, size: pv_ff.size};
               rover_in        = prev_ff;
               res_addr_in     = p_ff + 12'd1;
               res_stat_in     = STAT_OK;
               state_in        = ST_DONE;
            end else if (mem_rdata.size > units_ff) begin
               // split: shrink, then tag the tail
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = p_ff;
               mem_req.wr_data = '{next: mem_rdata.next, size: rem};
               mem_req.rd_addr = q_addr;
               q_in            = q_addr;
               state_in        = ST_A_SPLIT;
            end else if (p_ff == rover_ff) begin
               // lap done: grow the break
               if (brk_sum > 14'(HEAP_UNITS)) begin
                  res_addr_in = '0;
                  res_stat_in = STAT_OOM;
                  state_in    = ST_DONE;
               end else begin
                  mem_req.rd_addr = brk_ff[ADDR_W-1:0];
                  bp_in           = brk_ff[ADDR_W-1:0];
                  brk_in          = brk_sum[SIZE_W-1:0];
                  amt_in          = amount;
                  state_in        = ST_G_WR;
               end
            end else if (steps_ff >= STEP_LIMIT) begin
               res_addr_in = '0;
               res_stat_in = STAT_OOM;
               state_in    = ST_DONE;
            end else begin
               prev_in         = p_ff;
               pv_in           = mem_rdata;
               p_in            = mem_rdata.next;
               mem_req.rd_addr = mem_rdata.next;
               steps_in        = steps_ff + 13'd1;
            end
         end
         ST_A_SPLIT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = q_ff;
            mem_req.wr_data = '{next: mem_rdata.next, size: units_ff};
            rover_in        = prev_ff;
            res_addr_in     = q_ff + 12'd1;
            res_stat_in     = STAT_OK;
            state_in        = ST_DONE;
         end
         ST_G_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = bp_ff;
            mem_req.wr_data = '{next: mem_rdata.next, size: amt_ff};
            bh_in           = '{next: mem_rdata.next, size: amt_ff};
            grow_in         = 1'b1;
            state_in        = ST_I_ROV;
         end
         ST_I_BL: begin
            bh_in    = mem_rdata;
            state_in = ST_I_ROV;
         end
         ST_I_ROV: begin
            mem_req.rd_addr = rover_ff;
            p_in            = rover_ff;
            steps_in        = '0;
            state_in        = ST_I_WALK;
         end
         ST_I_WALK: begin
            mem_req.rd_addr = nx;
            if (ins_found) begin
               cur_in   = mem_rdata;
               state_in = ST_I_N;
            end else begin
               p_in     = nx;
               steps_in = steps_ff + 13'd1;
            end
         end
         ST_I_N: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = bp_ff;
            mem_req.wr_data = b_new;
            bh_in           = b_new;
            state_in        = ST_I_W2;
         end
         ST_I_W2: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = p_ff;
            mem_req.wr_data = p_new;
            rover_in        = p_ff;
            if (grow_ff) begin
               // resume the allocate walk from the new rover
               prev_in  = p_ff;
               pv_in    = p_new;
               p_in     = p_new.next;
               steps_in = '0;
               state_in = ST_A_FETCH;
            end else begin
               res_addr_in = '0;
               res_stat_in = STAT_OK;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               res.valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/first_fit_free_list_allocator_top.sv
// First-fit free-list allocator over a 4096-unit heap of 16-byte units.
// Request beat: req_func 0 allocates req_request_bytes, 1 frees the block
// whose payload unit index is req_block_address. Every request gives one
// response beat: rsp_payload_address (header index plus one, 0 on a free or
// failure) and rsp_status (1 means out of memory).
// csr_grow_min_units sets the least growth of the heap break; write it only
// while no request is in flight.
// One request at a time. An allocate walks the free list from the rover, one
// free header per step; a split adds a write of the tail header. When the
// heap has to grow, the new block goes through the insertion walk and then
// the allocate walk resumes. A free reads its header, then walks to its place.
// Every walk step is one read of the header RAM.
// Reset (synchronous) sets rover to the sentinel, the break to 1 and the
// growth minimum to 1024; after reset the INIT state writes the sentinel
// header, during which req_stall stays high.
// A stalled response is held in the output register; the block may accept
// the next request meanwhile and holds its result until the slot frees.
module first_fit_free_list_allocator_top
   import ffa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [15:0]       req_request_bytes,
   input  logic [ADDR_W-1:0] req_block_address,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ADDR_W-1:0] rsp_payload_address,
   output logic              rsp_status,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_grow_min_units
);

   logic [SIZE_W-1:0] grow_min_ff, grow_min_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic              rsp_stat_ff, rsp_stat_in;
   logic              rsp_free;
   hdr_type           mem_rdata;
   mem_req_type       mem_req;
   res_type           res;

   // Growth minimum register
   assign csr_ready   = 1'b1;
   assign grow_min_in = csr_valid ? csr_grow_min_units : grow_min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grow_min_ff <= GROW_MIN_RESET;
      end else begin
         grow_min_ff <= grow_min_in;
      end
   end

   // Header memory
   ffa_ram #(
      .WIDTH(HDR_W),
      .DEPTH(HEAP_UNITS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rdata)
   );

   ffa_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_request_bytes (req_request_bytes),
      .req_block_address (req_block_address),
      .grow_min          (grow_min_ff),
      .mem_rdata         (mem_rdata),
      .mem_req           (mem_req),
      .rsp_free          (rsp_free),
      .res               (res)
   );

   // Response output register
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res.valid || (rsp_valid_ff && rsp_stall);
   assign rsp_addr_in  = res.valid ? res.addr : rsp_addr_ff;
   assign rsp_stat_in  = res.valid ? res.status : rsp_stat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_addr_ff <= rsp_addr_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_address = rsp_addr_ff;
   assign rsp_status          = rsp_stat_ff;

endmodule

FILE: tb/sv/tb_first_fit_free_list_allocator_top.sv
module tb_first_fit_free_list_allocator_top;
   import ffa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 60000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_func;
   logic [15:0]       req_request_bytes;
   logic [ADDR_W-1:0] req_block_address;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [ADDR_W-1:0] rsp_payload_address;
   logic              rsp_status;
   logic              csr_valid;
   logic              csr_ready;
   logic [SIZE_W-1:0] csr_grow_min_units;

   first_fit_free_list_allocator_top dut (.*);

   // Expected response beat
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              status;
   } alloc_result_type;

   alloc_result_type result_q[$];
   int unsigned      live_blocks[$];   // payload addresses handed out and not yet freed
   int               errors = 0;
   int               sender_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               hold_cycles = 0;
   bit               hold_req = 1'b0;
   bit               hold_done = 1'b0;

   // Shadow heap state
   logic [ADDR_W-1:0] heap_link[HEAP_UNITS];
   logic [SIZE_W-1:0] heap_size[HEAP_UNITS];
   int unsigned       rover;
   int unsigned       brk;
   int unsigned       grow_min;

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
   endtask

   // Insert header bp into the address-ordered list, merging neighbors
   function automatic void link_block(input int unsigned bp);
      int unsigned p, nx, steps;
      p = rover;
      steps = 0;
      while (1) begin
         nx = heap_link[p];
         if (bp > p && bp < nx) break;
         if (p >= nx && (bp > p || bp < nx)) break;
         steps++;
         if (steps > HEAP_UNITS) break;
         p = nx;
      end
      nx = heap_link[p];
      if (bp + heap_size[bp] == nx) begin
         heap_size[bp] = heap_size[bp] + heap_size[nx];
         heap_link[bp] = heap_link[nx];
      end else begin
         heap_link[bp] = ADDR_W'(nx);
      end
      if (p + heap_size[p] == bp) begin
         heap_size[p] = heap_size[p] + heap_size[bp];
         heap_link[p] = heap_link[bp];
      end else begin
         heap_link[p] = ADDR_W'(bp);
      end
      rover = p;
   endfunction

   function automatic bit grow_break(input int unsigned units);
      int unsigned amount, base;
      amount = (units < grow_min) ? grow_min : units;
      if (brk + amount > HEAP_UNITS) return 0;
      base = brk;
      heap_size[base] = SIZE_W'(amount);
      brk += amount;
      link_block(base);
      return 1;
   endfunction

   // First-fit allocate; returns payload index or 0 with failure flag
   function automatic bit first_fit(input int unsigned nbytes, output int unsigned payload);
      int unsigned units, prev, p, steps, sz, rem;
      units = (nbytes + UNIT_BYTES - 1) / UNIT_BYTES + 1;
      prev = rover;
      p = heap_link[prev];
      steps = 0;
      payload = 0;
      while (1) begin
         sz = heap_size[p];
         if (sz >= units) begin
            if (sz == units) begin
               heap_link[prev] = heap_link[p];
            end else begin
               rem = sz - units;
               heap_size[p] = SIZE_W'(rem);
               p = (p + rem) % HEAP_UNITS;
               heap_size[p] = SIZE_W'(units);
            end
            rover = prev;
            payload = (p + 1) % HEAP_UNITS;
            return 1;
         end
         if (p == rover) begin
            if (!grow_break(units)) return 0;
            p = rover;
            steps = 0;
         end else begin
            steps++;
            if (steps > HEAP_UNITS) return 0;
         end
         prev = p;
         p = heap_link[p];
      end
   endfunction

   function automatic alloc_result_type predict_beat(input logic func, input int unsigned nbytes,
                                                     input int unsigned baddr);
      alloc_result_type r;
      int unsigned      pay;
      r = '0;
      if (func == FUNC_ALLOC) begin
         if (first_fit(nbytes, pay)) begin
            r.addr = ADDR_W'(pay);
            r.status = STAT_OK;
            live_blocks.push_back(pay);
         end else begin
            r.status = STAT_OOM;
         end
      end else begin
         link_block((baddr + HEAP_UNITS - 1) % HEAP_UNITS);
      end
      return r;
   endfunction

   // Directed rows: sel picks a live block for frees (1 newest, 2 oldest)
   typedef struct {
      logic        func;
      int unsigned nbytes;
      int          sel;
      bit          typed;
      int unsigned exp_addr;
      logic        exp_status;
   } stim_row_type;

   stim_row_type directed[] = '{
      '{FUNC_ALLOC, 0,     0, 1, 1025, STAT_OK},
      '{FUNC_ALLOC, 65535, 0, 1, 0,    STAT_OOM},
      '{FUNC_ALLOC, 1,     0, 0, 0,    STAT_OK},
      '{FUNC_ALLOC, 16,    0, 0, 0,    STAT_OK},
      '{FUNC_ALLOC, 17,    0, 0, 0,    STAT_OK},
      '{FUNC_FREE,  0,     1, 0, 0,    STAT_OK},
      '{FUNC_ALLOC, 17,    0, 0, 0,    STAT_OK},
      '{FUNC_FREE,  0,     2, 0, 0,    STAT_OK},
      '{FUNC_ALLOC, 4000,  0, 0, 0,    STAT_OK},
      '{FUNC_ALLOC, 16383, 0, 0, 0,    STAT_OK},
      '{FUNC_ALLOC, 32768, 0, 0, 0,    STAT_OK},
      '{FUNC_FREE,  0,     1, 0, 0,    STAT_OK},
      '{FUNC_FREE,  0,     1, 0, 0,    STAT_OK},
      '{FUNC_ALLOC, 65535, 0, 1, 0,    STAT_OOM},
      '{FUNC_FREE,  0,     2, 0, 0,    STAT_OK},
      '{FUNC_ALLOC, 0,     0, 0, 0,    STAT_OK},
      '{FUNC_FREE,  0,     1, 0, 0,    STAT_OK}
   };

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Drive one request beat and predict it when accepted
   task automatic send_beat(input logic func, input int unsigned nbytes, input int unsigned baddr,
                            input bit typed, input alloc_result_type typed_res);
      alloc_result_type r;
      int               gap;
      req_valid         <= 1'b1;
      req_func          <= func;
      req_request_bytes <= 16'(nbytes);
      req_block_address <= ADDR_W'(baddr);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = predict_beat(func, nbytes, baddr);
      result_q.push_back(typed ? typed_res : r);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Pick a random request shaped like real use
   task automatic send_random();
      int unsigned nbytes, baddr, k, pick;
      logic        func;
      k = $urandom_range(0, 99);
      func = (live_blocks.size() > 0 &&
              (k < 45 || live_blocks.size() > 40)) ? FUNC_FREE : FUNC_ALLOC;
      pick = $urandom_range(0, 99);
      if (pick < 70)      nbytes = $urandom_range(0, 255);
      else if (pick < 90) nbytes = $urandom_range(0, 4095);
      else if (pick < 97) nbytes = $urandom_range(0, 20000);
      else                nbytes = $urandom_range(0, 65535);
      baddr = $urandom_range(0, 4095);
      if (func == FUNC_FREE) begin
         k = $urandom_range(0, live_blocks.size() - 1);
         baddr = live_blocks[k];
         live_blocks.delete(k);
      end
      send_beat(func, nbytes, baddr, 0, '0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (result_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_grow_min(input int unsigned value);
      csr_valid          <= 1'b1;
      csr_grow_min_units <= SIZE_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      grow_min = value & 13'h1FFF;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Main stimulus
   initial begin
      int unsigned      grow_setting[6];
      alloc_result_type tr;
      int unsigned      baddr;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_func           = FUNC_ALLOC;
      req_request_bytes  = '0;
      req_block_address  = '0;
      csr_valid          = 1'b0;
      csr_grow_min_units = '0;
      foreach (heap_link[i]) begin
         heap_link[i] = '0;
         heap_size[i] = '0;
      end
      rover = 0;
      brk = 1;
      grow_min = GROW_MIN_RESET;
      grow_setting = '{1, 4096, 0, 8191, 1024, 1};
      grow_setting[5] = $urandom_range(1, 4096);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      foreach (directed[i]) begin
         baddr = $urandom_range(1, 4095);
         if (directed[i].sel != 0) begin
            if (directed[i].sel == 1) baddr = live_blocks.pop_back();
            else baddr = live_blocks.pop_front();
         end
         tr.addr = ADDR_W'(directed[i].exp_addr);
         tr.status = directed[i].exp_status;
         send_beat(directed[i].func, directed[i].nbytes, baddr, directed[i].typed, tr);
      end
      drain();

      // Random phases, the first six each setting a growth minimum, each with an idling mix
      for (int ph = 0; ph < 7; ph++) begin
         if (ph < 6) write_grow_min(grow_setting[ph]);
         case (ph % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin sender_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         if (ph == 4) hold_req = 1'b1;
         repeat (90) send_random();
         drain();
      end

      if (errors == 0) begin
         $display("first_fit_free_list_allocator_top verification clean");
      end else begin
         $display("first_fit_free_list_allocator_top verification failed");
      end
      $finish;
   end

   // Response side: stall pattern and one long hold-off
   always @(posedge clock) begin
      if (hold_req && !hold_done) begin
         hold_done   <= 1'b1;
         hold_cycles <= 300;
         rsp_stall   <= 1'b1;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Compare each response beat with the oldest expectation
   always @(posedge clock) begin
      alloc_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (result_q.size() == 0) begin
            report_mismatch($sformatf("unexpected beat addr=%0d status=%0b",
                                      rsp_payload_address, rsp_status));
         end else begin
            e = result_q.pop_front();
            if (rsp_payload_address !== e.addr)
               report_mismatch($sformatf("payload_address got %0d want %0d",
                                         rsp_payload_address, e.addr));
            if (rsp_status !== e.status)
               report_mismatch($sformatf("status got %0b want %0b", rsp_status, e.status));
         end
      end
   end

   // Watchdog on cycles without any beat
   int idle_count = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_count <= 0;
      end else if (idle_count >= IDLE_LIMIT) begin
         $display("first_fit_free_list_allocator_top verification failed");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

endmodule
